>>> src/dbph_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbph_pkg - shared types and constants
// Register indexes, reset values and the tick control bundle used by the
// one-shot timers.
// ----------------------------------------------------------------------------
package dbph_pkg;

  localparam int COUNTER_WIDTH_DEF = 16;
  localparam int DEB_W             = 8;
  localparam int LEN_W             = 16;
  localparam int CFG_ADDR_W        = 2;
  localparam int CFG_DATA_W        = 16;
  localparam int IN_DATA_W         = 8;
  localparam int OUT_DATA_W        = 8;

  localparam logic [DEB_W-1:0] DEBOUNCE_RST = DEB_W'(50);
  localparam logic [LEN_W-1:0] PULSE_RST    = LEN_W'(100);
  localparam logic [LEN_W-1:0] HOLD_RST     = LEN_W'(3000);

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_PULSE    = 2'd1,
    CFG_HOLD     = 2'd2
  } cfg_reg_t;

  // per-tick control from the pipeline and debouncer to each timer
  typedef struct packed {
    logic adv;
    logic start;
  } tick_ctl_t;

endpackage

>>> src/dbph_debounce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbph_debounce - raw level debouncer
// Counts ticks of unchanged raw level and flags a newly accepted press.
// ----------------------------------------------------------------------------
module dbph_debounce import dbph_pkg::*; #(
  parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             raw,
  input  logic [DEB_W-1:0] debounce_ticks,
  output logic             press
);

  localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = '1;

  logic                     last_raw_r, last_raw_nxt;
  logic                     stable_r, stable_nxt;
  logic [COUNTER_WIDTH-1:0] steady_r, steady_nxt;
  logic                     accept;

  always_comb begin
    if (raw != last_raw_r) begin
      steady_nxt = '0;
    end else if (steady_r == CNT_MAX) begin
      steady_nxt = CNT_MAX;
    end else begin
      steady_nxt = steady_r + COUNTER_WIDTH'(1);
    end
    last_raw_nxt = raw;
    accept       = (steady_nxt > COUNTER_WIDTH'(debounce_ticks)) && (raw != stable_r);
    stable_nxt   = accept ? raw : stable_r;
    press        = accept && raw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r <= 1'b0;
      stable_r   <= 1'b0;
      steady_r   <= '0;
    end else if (adv) begin
      last_raw_r <= last_raw_nxt;
      stable_r   <= stable_nxt;
      steady_r   <= steady_nxt;
    end
  end

endmodule

>>> src/dbph_oneshot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbph_oneshot - retriggerable one-shot timer
// Counts elapsed ticks while running and stops once the length is reached.
// ----------------------------------------------------------------------------
module dbph_oneshot import dbph_pkg::*; #(
  parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  tick_ctl_t        ctl,
  input  logic [LEN_W-1:0] len,
  output logic             running
);

  localparam int CMP_W = (COUNTER_WIDTH > LEN_W) ? COUNTER_WIDTH : LEN_W;
  localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = '1;

  logic                     running_r, running_nxt;
  logic [COUNTER_WIDTH-1:0] elapsed_r, elapsed_nxt;
  logic                     run_mid;
  logic                     expire;

  always_comb begin
    run_mid     = running_r;
    elapsed_nxt = elapsed_r;
    if (running_r && (elapsed_r != CNT_MAX)) begin
      elapsed_nxt = elapsed_r + COUNTER_WIDTH'(1);
    end
    // retrigger restarts from zero
    if (ctl.start) begin
      run_mid     = 1'b1;
      elapsed_nxt = '0;
    end
    expire = (CMP_W'(elapsed_nxt) >= CMP_W'(len)) || (elapsed_nxt == CNT_MAX);
    running_nxt = run_mid && !expire;
    running     = running_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      elapsed_r <= '0;
    end else if (ctl.adv) begin
      running_r <= running_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

endmodule

>>> src/debounced_button_pulse_and_hold.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debounced_button_pulse_and_hold - debounced button with relay and lamp timers
// Path: an input transfer reaches a result transfer through the input reg
// and the result reg.
// Throughput: one tick per cycle while out_tready keeps the result slot free.
// Reset: synchronous active-low rst_n clears pipeline, state and timers and
// loads the configuration registers with their default values.
// ----------------------------------------------------------------------------
module debounced_button_pulse_and_hold import dbph_pkg::*; #(
  parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [0] raw_pressed
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [0] relay_idle (pulse not running), [1] lamp_on, [2] press_seen
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [DEB_W-1:0] debounce_r;
  logic [LEN_W-1:0] pulse_r;
  logic [LEN_W-1:0] hold_r;

  logic      s1_valid_r;
  logic      s1_raw_r;
  logic      out_valid_r;
  logic [2:0] out_bits_r, out_bits_nxt;
  logic      out_free;
  logic      adv;
  logic      press;
  logic      pulse_running;
  logic      lamp_running;
  tick_ctl_t tick_ctl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RST;
      pulse_r    <= PULSE_RST;
      hold_r     <= HOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_DEBOUNCE: debounce_r <= cfg_wdata[DEB_W-1:0];
        CFG_PULSE:    pulse_r    <= cfg_wdata[LEN_W-1:0];
        CFG_HOLD:     hold_r     <= cfg_wdata[LEN_W-1:0];
        default:      ;
      endcase
    end
  end

  // the tick in the input register advances whenever the result slot is free
  assign out_free  = !out_valid_r || out_tready;
  assign adv       = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  assign tick_ctl.adv   = adv;
  assign tick_ctl.start = press;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_raw_r <= in_tdata[0];
    end
  end

  dbph_debounce #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_debounce (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .raw           (s1_raw_r),
    .debounce_ticks(debounce_r),
    .press         (press)
  );

  dbph_oneshot #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_pulse (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (tick_ctl),
    .len    (pulse_r),
    .running(pulse_running)
  );

  dbph_oneshot #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_lamp (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (tick_ctl),
    .len    (hold_r),
    .running(lamp_running)
  );

  assign out_bits_nxt = {press, lamp_running, !pulse_running};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_bits_r <= out_bits_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-3){1'b0}}, out_bits_r};

endmodule
